// ----- rtl/core/spq_pkg.sv -----
package spq_pkg;

    // Heap geometry and field widths.
    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CH_W     = IDX_W + 2;
    localparam int FIELD_W  = 30;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;

    // Largest identifier or priority that a push may carry.
    localparam logic [FIELD_W-1:0] VALUE_MAX = FIELD_W'(1000000000);

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_PUSH_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PUSH_REJ  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POP_OK    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd3;

    typedef struct packed {
        logic               op;
        logic [FIELD_W-1:0] item_id;
        logic [FIELD_W-1:0] prio;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  out_id;
    } t_out_item;

    // One stored heap slot.
    typedef struct packed {
        logic [FIELD_W-1:0] item_id;
        logic [FIELD_W-1:0] prio;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

// ----- rtl/core/spq_order.sv -----
module spq_order (
    input  spq_pkg::t_entry i_a,
    input  spq_pkg::t_entry i_b,
    output logic            o_ahead
);
    import spq_pkg::*;

    // Entry a is served before entry b: higher priority wins, and on a tie the
    // older stamp wins.
    always_comb begin
        if (i_a.prio != i_b.prio) begin
            o_ahead = (i_a.prio > i_b.prio);
        end else begin
            o_ahead = (i_a.stamp < i_b.stamp);
        end
    end

endmodule

// ----- rtl/core/stable_priority_queue_top.sv -----
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_stall      i_in_item  (op, item_id, prio)
// result    out        o_out_valid / i_out_stall    o_out_item (status, out_id)
//
// Each item gives one result item. A rejected push or an empty pop goes straight to the
// hand-over state, a draining pop only fetches the root, an accepted push compares against
// parents on its way up, and any other pop descends level by level until it settles. The
// single compare unit and the heap memory's registered read are used at each level.
// Reset (synchronous, active low) empties the queue and clears the arrival counter; only live
// slots are read, so the heap needs no clearing. A stalled result waits in the output register.
module stable_priority_queue_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  spq_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output spq_pkg::t_out_item  o_out_item
);
    import spq_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_POP_RD = 4'd1;
    localparam logic [3:0] S_POP_LD = 4'd2;
    localparam logic [3:0] S_UP_RD  = 4'd3;
    localparam logic [3:0] S_UP_CMP = 4'd4;
    localparam logic [3:0] S_DN_RD  = 4'd5;
    localparam logic [3:0] S_DN_SEL = 4'd6;
    localparam logic [3:0] S_DN_CMP = 4'd7;
    localparam logic [3:0] S_WR     = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STAMP_W-1:0]  r_arrival, n_arrival;
    logic [IDX_W-1:0]    r_pos, n_pos;
    t_entry              r_cur, n_cur;
    t_entry              r_win, n_win;
    logic [IDX_W-1:0]    r_win_idx, n_win_idx;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [FIELD_W-1:0]  r_res_id, n_res_id;
    logic                r_out_vld, n_out_vld;
    t_out_item           r_out, n_out;

    // Heap storage with one write port and two registered read ports.
    t_entry              r_heap [CAPACITY];
    t_entry              r_rd_a, r_rd_b;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    t_entry              mem_wdata;
    logic [IDX_W-1:0]    mem_raddr_a, mem_raddr_b;

    t_entry              cmp_a, cmp_b;
    logic                cmp_ahead;

    logic                in_acc;
    logic                out_free;
    logic                push_ok;
    logic [IDX_W-1:0]    parent_idx;
    logic [CH_W-1:0]     left_idx, right_idx;
    logic                left_ok, right_ok;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // A push is taken only with both fields in range, a free slot and a stamp
    // that can still be advanced.
    assign push_ok = (i_in_item.item_id != '0) && (i_in_item.item_id <= VALUE_MAX) &&
                     (i_in_item.prio != '0) && (i_in_item.prio <= VALUE_MAX) &&
                     (r_count != CNT_W'(CAPACITY)) && (r_arrival != '1);

    // Tree links of the current hole.
    assign parent_idx = IDX_W'((r_pos - 1'b1) >> 1);
    assign left_idx   = (CH_W'(r_pos) << 1) | CH_W'(1);
    assign right_idx  = left_idx + CH_W'(1);
    assign left_ok    = (left_idx < CH_W'(r_count));
    assign right_ok   = (right_idx < CH_W'(r_count));

    // The one comparator, shared by every step of both sifts.
    spq_order u_order (
        .i_a     (cmp_a),
        .i_b     (cmp_b),
        .o_ahead (cmp_ahead)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_arrival    = r_arrival;
        n_pos        = r_pos;
        n_cur        = r_cur;
        n_win        = r_win;
        n_win_idx    = r_win_idx;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        mem_we       = 1'b0;
        mem_waddr    = r_pos;
        mem_wdata    = r_cur;
        mem_raddr_a  = parent_idx;
        mem_raddr_b  = '0;
        cmp_a        = r_cur;
        cmp_b        = r_rd_a;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res_id = '0;
                    if (i_in_item.op == OP_PUSH) begin
                        if (!push_ok) begin
                            n_res_status = ST_PUSH_REJ;
                            n_state      = S_DONE;
                        end else begin
                            n_res_status  = ST_PUSH_OK;
                            n_cur.item_id = i_in_item.item_id;
                            n_cur.prio    = i_in_item.prio;
                            n_cur.stamp   = r_arrival;
                            n_arrival     = r_arrival + 1'b1;
                            n_pos         = r_count[IDX_W-1:0];
                            n_count       = r_count + 1'b1;
                            n_state       = (r_count == '0) ? S_WR : S_UP_RD;
                        end
                    end else if (r_count == '0) begin
                        n_res_status = ST_POP_EMPTY;
                        n_state      = S_DONE;
                    end else begin
                        n_res_status = ST_POP_OK;
                        n_count      = r_count - 1'b1;
                        if (r_count == CNT_W'(1)) begin
                            n_arrival = '0;
                        end
                        n_state = S_POP_RD;
                    end
                end
            end
            S_POP_RD: begin
                // Fetch the root and the last live slot together.
                mem_raddr_a = '0;
                mem_raddr_b = r_count[IDX_W-1:0];
                n_state     = S_POP_LD;
            end
            S_POP_LD: begin
                n_res_id = r_rd_a.item_id;
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cur   = r_rd_b;
                    n_pos   = '0;
                    n_state = S_DN_RD;
                end
            end
            S_UP_RD: begin
                mem_raddr_a = parent_idx;
                n_state     = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (cmp_ahead) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_a;
                    n_pos     = parent_idx;
                    n_state   = (parent_idx == '0) ? S_WR : S_UP_RD;
                end else begin
                    n_state = S_WR;
                end
            end
            S_DN_RD: begin
                mem_raddr_a = left_idx[IDX_W-1:0];
                mem_raddr_b = right_idx[IDX_W-1:0];
                n_state     = left_ok ? S_DN_SEL : S_WR;
            end
            S_DN_SEL: begin
                cmp_a = r_rd_b;
                cmp_b = r_rd_a;
                if (right_ok && cmp_ahead) begin
                    n_win     = r_rd_b;
                    n_win_idx = right_idx[IDX_W-1:0];
                end else begin
                    n_win     = r_rd_a;
                    n_win_idx = left_idx[IDX_W-1:0];
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                cmp_a = r_win;
                cmp_b = r_cur;
                if (cmp_ahead) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_win;
                    n_pos     = r_win_idx;
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                // The travelling entry settles in the hole.
                mem_we  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: loaded from the finished item, cleared when taken.
    always_comb begin
        n_out_vld = r_out_vld && i_out_stall;
        n_out     = r_out;
        if ((r_state == S_DONE) && out_free) begin
            n_out_vld     = 1'b1;
            n_out.status  = r_res_status;
            n_out.out_id  = r_res_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_arrival <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_arrival <= n_arrival;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_cur        <= n_cur;
        r_win        <= n_win;
        r_win_idx    <= n_win_idx;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_out        <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_heap[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= r_heap[mem_raddr_a];
        r_rd_b <= r_heap[mem_raddr_b];
    end

    // The live count never passes the heap size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // An empty queue always has its arrival counter back at zero.
    a_empty_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_arrival == '0))
        else $error("arrival counter not cleared on empty queue");

    // A result appears only from the hand-over state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result loaded outside hand-over");

    // The hole being sifted always lies inside the live part of the heap.
    a_hole_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UP_RD) || (r_state == S_DN_RD)) |-> (CNT_W'(r_pos) < r_count))
        else $error("sift position outside live entries");

    // The heap is written only while an item is being worked on.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state != S_IDLE) && (r_state != S_DONE)))
        else $error("heap written while not busy");

endmodule

// ----- tb/testbench.sv -----
module testbench;

    import spq_pkg::*;

    // The testbench only ever gives up on a queue that has gone quiet: this many
    // cycles with neither an input item nor a result item handed over. The slowest
    // correct item (a deep sift-down) plus the longest sender gap and a long
    // receiver stall stays well under it.
    localparam int IDLE_LIMIT   = 2000;
    // Cycles to watch after the last expected result, to catch any stray result.
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 360;

    // Ways in which the receiving side holds off results.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BEAT
    } t_stall_mode;

    // One row of the directed table: the item and the result that it must give.
    typedef struct {
        t_in_item  stim;
        t_out_item want;
    } t_directed_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;

    // Our own copy of the queue: heap slots, live entry count, next arrival stamp.
    t_entry             heap_slot [CAPACITY];
    int                 live_count = 0;
    logic [STAMP_W-1:0] next_stamp = '0;

    // Results still owed by the block, oldest first.
    t_out_item      awaited_results [$];
    t_directed_row  directed_rows [$];

    int             error_count = 0;
    int             idle_cycles = 0;
    int             burst_left = 0;
    t_stall_mode    stall_mode = STALL_NONE;
    int             pattern_left = 0;

    stable_priority_queue_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #10 clk = ~clk;

    // An entry is served first if its priority is higher, or if the priorities are
    // equal and it arrived earlier. This is what makes the queue stable on ties.
    function automatic bit served_first(input t_entry a, input t_entry b);
        if (a.prio != b.prio)
            return a.prio > b.prio;
        return a.stamp < b.stamp;
    endfunction

    // Applies one item to our copy of the queue and returns the result that the
    // block must give for it.
    function automatic t_out_item apply_queue_op(input t_in_item req);
        t_out_item res;
        t_entry    tmp;
        int        pos;
        int        parent;
        int        lchild;
        int        best;
        bit        settled;
        res.status = ST_PUSH_OK;
        res.out_id = '0;
        if (req.op == OP_PUSH) begin
            // A push is turned away for a field out of range, a full queue, or an
            // arrival counter that has no stamp left to give.
            if (req.item_id == '0 || req.item_id > VALUE_MAX ||
                req.prio == '0 || req.prio > VALUE_MAX ||
                live_count >= CAPACITY || next_stamp == '1) begin
                res.status = ST_PUSH_REJ;
            end else begin
                heap_slot[live_count].item_id = req.item_id;
                heap_slot[live_count].prio    = req.prio;
                heap_slot[live_count].stamp   = next_stamp;
                next_stamp = next_stamp + 1'b1;
                pos = live_count;
                live_count++;
                settled = 1'b0;
                while (pos > 0 && !settled) begin
                    parent = (pos - 1) / 2;
                    if (served_first(heap_slot[pos], heap_slot[parent])) begin
                        tmp               = heap_slot[pos];
                        heap_slot[pos]    = heap_slot[parent];
                        heap_slot[parent] = tmp;
                        pos = parent;
                    end else begin
                        settled = 1'b1;
                    end
                end
            end
        end else if (live_count == 0) begin
            res.status = ST_POP_EMPTY;
        end else begin
            res.status = ST_POP_OK;
            res.out_id = heap_slot[0].item_id;
            live_count--;
            if (live_count > 0) begin
                heap_slot[0] = heap_slot[live_count];
                pos = 0;
                settled = 1'b0;
                while (!settled) begin
                    lchild = 2 * pos + 1;
                    best = pos;
                    if (lchild < live_count && served_first(heap_slot[lchild], heap_slot[best]))
                        best = lchild;
                    if (lchild + 1 < live_count &&
                        served_first(heap_slot[lchild + 1], heap_slot[best]))
                        best = lchild + 1;
                    if (best == pos) begin
                        settled = 1'b1;
                    end else begin
                        tmp             = heap_slot[pos];
                        heap_slot[pos]  = heap_slot[best];
                        heap_slot[best] = tmp;
                        pos = best;
                    end
                end
            end else begin
                // Emptying the queue starts the arrival stamps again from zero.
                next_stamp = '0;
            end
        end
        return res;
    endfunction

    task automatic add_row(input logic op, input int unsigned id, input int unsigned prio,
                           input logic [STATUS_W-1:0] status, input int unsigned out_id);
        t_directed_row row;
        row.stim.op      = op;
        row.stim.item_id = FIELD_W'(id);
        row.stim.prio    = FIELD_W'(prio);
        row.want.status  = status;
        row.want.out_id  = FIELD_W'(out_id);
        directed_rows.push_back(row);
    endtask

    // Builds a random item. push_pct sets the share of pushes; span sets the
    // priorities: zero for the full legal range, negative for the two extremes
    // only, and otherwise 1 to span, which gives plenty of equal priorities.
    function automatic t_in_item random_request(input int push_pct, input int span);
        t_in_item req;
        req.item_id = FIELD_W'($urandom);
        req.prio    = FIELD_W'($urandom);
        if ($urandom_range(0, 99) >= push_pct) begin
            // Pops carry random junk in the unused fields.
            req.op = OP_POP;
            return req;
        end
        req.op = OP_PUSH;
        if ($urandom_range(0, 99) < 8) begin
            // A malformed push: a zero or an out-of-range field.
            case ($urandom_range(0, 4))
                0: req.item_id = '0;
                1: req.prio = '0;
                2: req.item_id = VALUE_MAX + FIELD_W'($urandom_range(1, 1000));
                3: req.prio = VALUE_MAX + FIELD_W'($urandom_range(1, 1000));
                default: req.prio = '1;
            endcase
            return req;
        end
        req.item_id = FIELD_W'($urandom_range(1, VALUE_MAX));
        if (span == 0)
            req.prio = FIELD_W'($urandom_range(1, VALUE_MAX));
        else if (span < 0)
            req.prio = ($urandom_range(0, 1) != 0) ? VALUE_MAX : FIELD_W'(1);
        else
            req.prio = FIELD_W'($urandom_range(1, span));
        return req;
    endfunction

    // Hands one item to the block. The sender works in bursts: when a burst runs
    // out, valid drops for a random gap and a new burst length is drawn. Now and
    // then a burst is long, so that back-to-back items get exercised as well.
    // Once the item is accepted its result is worked out and queued; a directed
    // row passes its own typed result in place of the predicted one.
    task automatic send_request(input t_in_item req, input bit typed, input t_out_item want);
        t_out_item predicted;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 100);
            else
                burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        predicted = apply_queue_op(req);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    // Stimulus: the directed table, then random segments, then a full drain.
    initial begin
        t_directed_row row;
        t_out_item     none;
        int            random_sent;
        int            seg_len;
        int            push_pct;
        int            span;
        none = '0;
        random_sent = 0;

        // Directed table. Each expected result follows from the rules at a glance.
        // A pop straight after reset finds nothing.
        add_row(OP_POP,  0,          0,          ST_POP_EMPTY, 0);
        // Pushes with a zero or out-of-range field are turned away.
        add_row(OP_PUSH, 0,          5,          ST_PUSH_REJ,  0);
        add_row(OP_PUSH, 5,          0,          ST_PUSH_REJ,  0);
        add_row(OP_PUSH, 1000000001, 5,          ST_PUSH_REJ,  0);
        add_row(OP_PUSH, 5,          1000000001, ST_PUSH_REJ,  0);
        add_row(OP_PUSH, 'h3FFFFFFF, 'h3FFFFFFF, ST_PUSH_REJ,  0);
        // The legal extremes are taken, including ties on both the lowest and the
        // highest priority.
        add_row(OP_PUSH, 1,          1,          ST_PUSH_OK,   0);
        add_row(OP_PUSH, 1000000000, 1000000000, ST_PUSH_OK,   0);
        add_row(OP_PUSH, 7,          1000000000, ST_PUSH_OK,   0);
        add_row(OP_PUSH, 8,          1,          ST_PUSH_OK,   0);
        add_row(OP_PUSH, 9,          500,        ST_PUSH_OK,   0);
        // Highest priority first, and the earlier arrival first on a tie.
        add_row(OP_POP,  0,          0,          ST_POP_OK,    1000000000);
        add_row(OP_POP,  0,          0,          ST_POP_OK,    7);
        add_row(OP_POP,  0,          0,          ST_POP_OK,    9);
        add_row(OP_POP,  0,          0,          ST_POP_OK,    1);
        // This pop drains the queue, so the arrival counter starts again.
        add_row(OP_POP,  0,          0,          ST_POP_OK,    8);
        add_row(OP_POP,  0,          0,          ST_POP_EMPTY, 0);
        // Alternating bit patterns in legal values, again with a tie.
        add_row(OP_PUSH, 'h2AAAAAAA, 'h15555555, ST_PUSH_OK,   0);
        add_row(OP_PUSH, 3,          'h15555555, ST_PUSH_OK,   0);
        add_row(OP_POP,  0,          0,          ST_POP_OK,    'h2AAAAAAA);
        // A pop ignores whatever lies in its identifier and priority fields.
        add_row(OP_POP,  'h3FFFFFFF, 'h3FFFFFFF, ST_POP_OK,    3);
        add_row(OP_POP,  'h12345,    0,          ST_POP_EMPTY, 0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.stim, 1'b1, row.want);
        end

        // Random segments. Each one leans towards growing or shrinking the queue
        // and keeps to one style of priority, so that long runs of equal
        // priorities build up deep in the heap as well as widely spread ones.
        while (random_sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
                0: push_pct = 75;
                1: push_pct = 30;
                default: push_pct = 55;
            endcase
            case ($urandom_range(0, 3))
                0: span = 0;
                1: span = -1;
                2: span = 3;
                default: span = $urandom_range(4, 50);
            endcase
            repeat (seg_len) begin
                send_request(random_request(push_pct, span), 1'b0, none);
                random_sent++;
            end
        end

        // Empty whatever is left in the queue, then pop once more.
        while (live_count > 0)
            send_request(random_request(0, 0), 1'b0, none);
        send_request(random_request(0, 0), 1'b0, none);
        in_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result checking: every result handed over is matched against the oldest
    // outstanding expectation, field by field.
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("result item with none expected: status %0d, out_id %0d",
                       out_item.status, out_item.out_id);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (out_item.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, out_item.status);
                    error_count++;
                end
                if (out_item.out_id !== want.out_id) begin
                    $error("out_id mismatch: expected %0d, actual %0d",
                           want.out_id, out_item.out_id);
                    error_count++;
                end
            end
        end
    end

    // The receiver switches habits at random intervals: no stalls at all,
    // occasional stalls, mostly stalled, or a fixed beat that stalls for three
    // fifths of the time.
    always @(posedge clk) begin
        if (pattern_left == 0) begin
            stall_mode   <= t_stall_mode'($urandom_range(0, 3));
            pattern_left <= $urandom_range(20, 120);
        end else begin
            pattern_left <= pattern_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((pattern_left % 5) < 3);
        endcase
    end

    // Watchdog: ends the run if nothing moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
rtl/core/spq_pkg.sv
rtl/core/spq_order.sv
rtl/core/stable_priority_queue_top.sv
tb/testbench.sv
